FILE: design/mrrd_pkg.sv
package mrrd_pkg;

    localparam int CHAN_COUNT = 16;
    localparam int IDX_W      = $clog2(CHAN_COUNT);
    localparam int CNT_W      = $clog2(CHAN_COUNT + 1);

    localparam int OPCODE_W   = 2;
    localparam int CHANNEL_W  = 4;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND    = 2'd0,
        OP_SERVE   = 2'd1,
        OP_REPLY   = 2'd2,
        OP_COLLECT = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [CHANNEL_W-1:0]    channel_index;
        logic signed [WORD_W-1:0] reply_word;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [CHANNEL_W-1:0]     served_channel;
        logic signed [WORD_W-1:0] returned_word;
    } result_t;

endpackage

FILE: design/mrrd_item_if.sv
interface mrrd_item_if;

    logic                                valid;
    logic                                ready;
    logic [mrrd_pkg::OPCODE_W-1:0]       opcode;
    logic [mrrd_pkg::CHANNEL_W-1:0]      channel_index;
    logic signed [mrrd_pkg::WORD_W-1:0]  reply_word;

    modport source (
        output valid,
        output opcode,
        output channel_index,
        output reply_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  channel_index,
        input  reply_word,
        output ready
    );

endinterface

FILE: design/mrrd_result_if.sv
interface mrrd_result_if;

    logic                                valid;
    logic                                ready;
    logic [mrrd_pkg::STATUS_W-1:0]       status;
    logic [mrrd_pkg::CHANNEL_W-1:0]      served_channel;
    logic signed [mrrd_pkg::WORD_W-1:0]  returned_word;

    modport source (
        output valid,
        output status,
        output served_channel,
        output returned_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  served_channel,
        input  returned_word,
        output ready
    );

endinterface

FILE: design/mrrd_rr_find.sv
module mrrd_rr_find (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [mrrd_pkg::CHAN_COUNT-1:0]                  req_mask,
    input  logic [mrrd_pkg::IDX_W-1:0]                       start,
    output logic                                             found,
    output logic [mrrd_pkg::IDX_W-1:0]                       grant_idx
);

    logic [mrrd_pkg::CHAN_COUNT-1:0] upper_mask;
    logic [mrrd_pkg::CHAN_COUNT-1:0] upper_req;
    logic [mrrd_pkg::CHAN_COUNT-1:0] pick_req;
    logic [mrrd_pkg::CHAN_COUNT-1:0] grant_oh;

    // Requests at or above the start position win first; otherwise the search wraps.
    assign upper_mask = {mrrd_pkg::CHAN_COUNT{1'b1}} << start;
    assign upper_req  = req_mask & upper_mask;
    assign pick_req   = (|upper_req) ? upper_req : req_mask;
    assign grant_oh   = pick_req & (~pick_req + mrrd_pkg::CHAN_COUNT'(1));
    assign found      = |req_mask;

    always_comb
    begin
        grant_idx = '0;
        for (int i = 0; i < mrrd_pkg::CHAN_COUNT; i++)
        begin
            if (grant_oh[i])
            begin
                grant_idx = grant_idx | mrrd_pkg::IDX_W'(i);
            end
        end
    end

`ifndef SYNTHESIS
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> $onehot(grant_oh))
        else $error("grant is not one-hot while a request is pending");

    a_grant_is_request: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> req_mask[grant_idx])
        else $error("granted channel has no request");
`endif

endmodule

FILE: design/mrrd_bank.sv
module mrrd_bank (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mrrd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           exec,
    input  mrrd_pkg::item_t                item,
    output mrrd_pkg::result_t              result
);

    logic [mrrd_pkg::CHAN_COUNT-1:0] send_flag_reg;
    logic [mrrd_pkg::CHAN_COUNT-1:0] send_flag_next;
    logic [mrrd_pkg::CHAN_COUNT-1:0] reply_flag_reg;
    logic [mrrd_pkg::CHAN_COUNT-1:0] reply_flag_next;
    logic [mrrd_pkg::IDX_W-1:0]      ptr_reg;
    logic [mrrd_pkg::IDX_W-1:0]      ptr_next;
    logic [mrrd_pkg::CFG_W-1:0]      used_reg;
    logic [mrrd_pkg::WORD_W-1:0]     words_reg [mrrd_pkg::CHAN_COUNT];

    mrrd_pkg::op_t                   op;
    logic [mrrd_pkg::IDX_W-1:0]      ch;
    logic [mrrd_pkg::CNT_W-1:0]      n_eff;
    logic [mrrd_pkg::CHAN_COUNT-1:0] in_range;
    logic [mrrd_pkg::CHAN_COUNT-1:0] req_mask;
    logic [mrrd_pkg::IDX_W-1:0]      start;
    logic                            found;
    logic [mrrd_pkg::IDX_W-1:0]      grant_idx;
    logic [mrrd_pkg::CNT_W-1:0]      after_grant;
    logic                            ch_ok;
    logic                            word_we;

    assign op    = mrrd_pkg::op_t'(item.opcode);
    assign ch    = item.channel_index[mrrd_pkg::IDX_W-1:0];
    assign n_eff = (used_reg > mrrd_pkg::CFG_W'(mrrd_pkg::CHAN_COUNT))
                 ? mrrd_pkg::CNT_W'(mrrd_pkg::CHAN_COUNT)
                 : mrrd_pkg::CNT_W'(used_reg);

    always_comb
    begin
        for (int i = 0; i < mrrd_pkg::CHAN_COUNT; i++)
        begin
            in_range[i] = mrrd_pkg::CNT_W'(i) < n_eff;
        end
    end

    assign req_mask    = send_flag_reg & in_range;
    assign start       = (mrrd_pkg::CNT_W'(ptr_reg) < n_eff) ? ptr_reg : '0;
    assign ch_ok       = mrrd_pkg::CNT_W'(item.channel_index) < n_eff;
    assign after_grant = mrrd_pkg::CNT_W'(grant_idx) + mrrd_pkg::CNT_W'(1);

    mrrd_rr_find u_find (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_mask  (req_mask),
        .start     (start),
        .found     (found),
        .grant_idx (grant_idx)
    );

    always_comb
    begin
        send_flag_next        = send_flag_reg;
        reply_flag_next       = reply_flag_reg;
        ptr_next              = ptr_reg;
        word_we               = 1'b0;
        result.status         = mrrd_pkg::ST_DONE;
        result.served_channel = item.channel_index;
        result.returned_word  = '0;
        unique case (op)
            mrrd_pkg::OP_SERVE:
            begin
                if (found)
                begin
                    send_flag_next[grant_idx] = 1'b0;
                    result.served_channel     = mrrd_pkg::CHANNEL_W'(grant_idx);
                    ptr_next = (after_grant >= n_eff) ? '0
                             : after_grant[mrrd_pkg::IDX_W-1:0];
                end
                else
                begin
                    result.status = mrrd_pkg::ST_EMPTY;
                end
            end
            mrrd_pkg::OP_SEND:
            begin
                if (!ch_ok)
                begin
                    result.status = mrrd_pkg::ST_RANGE;
                end
                else
                begin
                    reply_flag_next[ch] = 1'b0;
                    send_flag_next[ch]  = 1'b1;
                end
            end
            mrrd_pkg::OP_REPLY:
            begin
                if (!ch_ok)
                begin
                    result.status = mrrd_pkg::ST_RANGE;
                end
                else
                begin
                    word_we             = 1'b1;
                    reply_flag_next[ch] = 1'b1;
                end
            end
            mrrd_pkg::OP_COLLECT:
            begin
                if (!ch_ok)
                begin
                    result.status = mrrd_pkg::ST_RANGE;
                end
                else if (reply_flag_reg[ch])
                begin
                    reply_flag_next[ch]  = 1'b0;
                    result.returned_word = words_reg[ch];
                end
                else
                begin
                    result.status = mrrd_pkg::ST_EMPTY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_flag_reg  <= '0;
            reply_flag_reg <= '0;
            ptr_reg        <= '0;
            used_reg       <= '0;
        end
        else
        begin
            if (exec)
            begin
                send_flag_reg  <= send_flag_next;
                reply_flag_reg <= reply_flag_next;
                ptr_reg        <= ptr_next;
            end
            if (cfg_we)
            begin
                used_reg <= cfg_wdata;
            end
        end
    end

    // A reply word is only read after a reply has written it, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (exec && word_we)
        begin
            words_reg[ch] <= item.reply_word;
        end
    end

`ifndef SYNTHESIS
    a_serve_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && op == mrrd_pkg::OP_SERVE && found) |=> !send_flag_reg[$past(grant_idx)])
        else $error("served channel still has its send flag raised");

    a_served_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && op == mrrd_pkg::OP_SERVE && found) |-> (mrrd_pkg::CNT_W'(grant_idx) < n_eff))
        else $error("served channel lies outside the channels in use");

    a_word_only_on_collect: assert property (@(posedge clk) disable iff (!rst_n)
        (result.returned_word != '0) |-> (op == mrrd_pkg::OP_COLLECT && ch_ok))
        else $error("nonzero word returned outside a successful collect");
`endif

endmodule

FILE: design/mailbox_round_robin_doorbell_core.sv
// Bank of sixteen mailbox channels with send, serve, reply and collect operations.
// One word enters per cycle on req while rsp is taken. It is held in an input register;
// when the result register is free or being read, the flag update and the round-robin
// search over the send flags of the channels in use land in the result register,
// which drives rsp. Throughput is one word per cycle while rsp is taken.
// Every word produces exactly one result word. A used_channels value above
// sixteen acts as sixteen; it should be written only while no word is in flight.
// After reset all flags are clear, the scan pointer is zero and no channel is in use.
module mailbox_round_robin_doorbell_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mrrd_pkg::CFG_W-1:0]    cfg_wdata,
    mrrd_item_if.sink                     req,
    mrrd_result_if.source                 rsp
);

    logic                in_valid_reg;
    mrrd_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    mrrd_pkg::result_t   out_result_reg;
    mrrd_pkg::result_t   result;
    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    mrrd_bank u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .exec      (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_item_reg   <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (req.ready && req.valid)
            begin
                in_item_reg.opcode        <= req.opcode;
                in_item_reg.channel_index <= req.channel_index;
                in_item_reg.reply_word    <= req.reply_word;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_result_reg.status;
    assign rsp.served_channel = out_result_reg.served_channel;
    assign rsp.returned_word  = out_result_reg.returned_word;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> req.ready)
        else $error("input stage empty but not ready");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word did not reach the result register");

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> in_valid_reg)
        else $error("accepted word did not reach the input register");
`endif

endmodule

FILE: bench/mailbox_checker.sv
`timescale 1ns / 100ps

module mailbox_checker
    import mrrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    mrrd_item_if             req,
    mrrd_result_if           rsp,
    output int               fail_count,
    output int               outstanding
);

    logic [CHAN_COUNT-1:0] send_flags;
    logic [CHAN_COUNT-1:0] reply_flags;
    logic [WORD_W-1:0]     reply_store [CHAN_COUNT];
    logic [IDX_W-1:0]      scan_ptr;
    logic [CFG_W-1:0]      used_count;
    result_t               due_results [$];

    function automatic result_t apply_mailbox_op(input op_t op,
                                                 input logic [CHANNEL_W-1:0] ch,
                                                 input logic [WORD_W-1:0] word);
        int      n;
        int      start;
        int      c;
        int      k;
        bit      found;
        result_t r;
        n = (used_count > CHAN_COUNT) ? CHAN_COUNT : int'(used_count);
        r.status         = ST_DONE;
        r.served_channel = ch;
        r.returned_word  = '0;
        if (op == OP_SERVE)
        begin
            r.status = ST_EMPTY;
            start    = (int'(scan_ptr) < n) ? int'(scan_ptr) : 0;
            found    = 1'b0;
            for (k = 0; k < n && !found; k++)
            begin
                c = (start + k) % n;
                if (send_flags[c])
                begin
                    send_flags[c]    = 1'b0;
                    r.served_channel = c[CHANNEL_W-1:0];
                    scan_ptr         = (c + 1 >= n) ? '0 : IDX_W'(c + 1);
                    r.status         = ST_DONE;
                    found            = 1'b1;
                end
            end
        end
        else if (int'(ch) >= n)
        begin
            r.status = ST_RANGE;
        end
        else if (op == OP_SEND)
        begin
            reply_flags[ch] = 1'b0;
            send_flags[ch]  = 1'b1;
        end
        else if (op == OP_REPLY)
        begin
            reply_store[ch] = word;
            reply_flags[ch] = 1'b1;
        end
        else if (reply_flags[ch])
        begin
            reply_flags[ch] = 1'b0;
            r.returned_word = reply_store[ch];
        end
        else
        begin
            r.status = ST_EMPTY;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            send_flags  = '0;
            reply_flags = '0;
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                reply_store[i] = '0;
            end
            scan_ptr    = '0;
            used_count  = '0;
            due_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                used_count = cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("Unexpected result word: status %0d channel %0d word %h",
                                 rsp.status, rsp.served_channel, rsp.returned_word);
                    end
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.served_channel !== want.served_channel ||
                        rsp.returned_word !== want.returned_word)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display({"Result mismatch: expected status %0d channel %0d ",
                                      "word %h, got status %0d channel %0d word %h"},
                                     want.status, want.served_channel, want.returned_word,
                                     rsp.status, rsp.served_channel, rsp.returned_word);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                due_results.push_back(apply_mailbox_op(op_t'(req.opcode),
                                                       req.channel_index,
                                                       req.reply_word));
            end
            outstanding = due_results.size();
        end
    end

endmodule

FILE: bench/mailbox_round_robin_doorbell_core_test.sv
`timescale 1ns / 100ps

module mailbox_round_robin_doorbell_core_test;

    import mrrd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {TAKE_ALL, TAKE_HALF, TAKE_QUARTER, TAKE_CYCLIC} take_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               used_now = 0;
    take_mode_t       take_mode = TAKE_ALL;
    int               mode_left = 0;

    mrrd_item_if   req_if ();
    mrrd_result_if rsp_if ();

    mailbox_round_robin_doorbell_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    mailbox_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_if),
        .rsp         (rsp_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL mailbox_round_robin_doorbell_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                take_mode = take_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (take_mode)
                TAKE_ALL:     rsp_if.ready <= 1'b1;
                TAKE_HALF:    rsp_if.ready <= 1'($urandom_range(0, 1));
                TAKE_QUARTER: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:      rsp_if.ready <= ((mode_left % 7) < 3);
            endcase
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input op_t op, input logic [CHANNEL_W-1:0] ch,
                             input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.channel_index <= ch;
        req_if.reply_word    <= word;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic set_channels(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        used_now  = (value > CHAN_COUNT) ? CHAN_COUNT : value;
    endtask

    task automatic run_traffic(input int count);
        int                   done;
        int                   k;
        logic [CHANNEL_W-1:0] picks [4];
        done = 0;
        while (done < count)
        begin
            if (used_now > 0 && $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                begin
                    picks[i] = CHANNEL_W'($urandom_range(0, used_now - 1));
                    send_word(OP_SEND, picks[i], pick_word());
                end
                for (int i = 0; i < k + $urandom_range(0, 1); i++)
                begin
                    send_word(OP_SERVE, CHANNEL_W'($urandom_range(0, 15)), pick_word());
                end
                for (int i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        send_word(OP_REPLY, picks[i], pick_word());
                    end
                end
                for (int i = 0; i < k; i++)
                begin
                    send_word(OP_COLLECT, picks[i], pick_word());
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_word(OP_COLLECT, picks[i], pick_word());
                    end
                end
                done += 4 * k;
            end
            else
            begin
                send_word(op_t'($urandom_range(0, 3)), CHANNEL_W'($urandom_range(0, 15)),
                          pick_word());
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_if.valid         <= 1'b0;
        req_if.opcode        <= OP_SEND;
        req_if.channel_index <= '0;
        req_if.reply_word    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no channels in use every access is out of range or empty.
        send_word(OP_SERVE, 4'd0, '0);
        send_word(OP_SEND, 4'd0, '0);
        send_word(OP_COLLECT, 4'd15, '0);
        send_word(OP_REPLY, 4'd0, 32'h1234_5678);

        set_channels(16);
        send_word(OP_SEND, 4'd0, '0);
        send_word(OP_SEND, 4'd15, '0);
        send_word(OP_SEND, 4'd5, '0);
        send_word(OP_SERVE, 4'd9, '0);
        send_word(OP_SERVE, 4'd0, '0);
        send_word(OP_SERVE, 4'd15, '0);
        send_word(OP_SERVE, 4'd3, '0);
        send_word(OP_REPLY, 4'd15, 32'h7fff_ffff);
        send_word(OP_REPLY, 4'd0, 32'h8000_0000);
        send_word(OP_COLLECT, 4'd15, '0);
        send_word(OP_COLLECT, 4'd15, '0);
        send_word(OP_COLLECT, 4'd0, '1);
        send_word(OP_REPLY, 4'd3, '1);
        send_word(OP_SEND, 4'd3, '0);
        send_word(OP_COLLECT, 4'd3, '0);
        send_word(OP_SEND, 4'd10, '0);
        send_word(OP_SERVE, 4'd0, '0);

        // The scan pointer now lies beyond the narrower range.
        set_channels(4);
        send_word(OP_SEND, 4'd2, '0);
        send_word(OP_SERVE, 4'd0, '0);

        set_channels(31);
        run_traffic(90);
        set_channels(1);
        run_traffic(90);
        set_channels(2);
        run_traffic(90);
        set_channels(17);
        run_traffic(90);
        set_channels(8);
        run_traffic(90);
        set_channels(16);
        run_traffic(90);
        set_channels(5);
        run_traffic(90);
        set_channels($urandom_range(0, 31));
        run_traffic(90);
        set_channels(12);
        run_traffic(90);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS mailbox_round_robin_doorbell_core");
        end
        else
        begin
            $display("FAIL mailbox_round_robin_doorbell_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mrrd_pkg.sv
design/mrrd_item_if.sv
design/mrrd_result_if.sv
design/mrrd_rr_find.sv
design/mrrd_bank.sv
design/mailbox_round_robin_doorbell_core.sv
bench/mailbox_checker.sv
bench/mailbox_round_robin_doorbell_core_test.sv
